### src/stepper_ramp_phase_generator_assert.svh
// Assertion macros used by the checker file.
`ifndef STEPPER_RAMP_PHASE_GENERATOR_ASSERT_SVH
`define STEPPER_RAMP_PHASE_GENERATOR_ASSERT_SVH

// Same-cycle implication under the asynchronous reset.
`define SRPG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under the asynchronous reset.
`define SRPG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/srpg_pkg.sv
`default_nettype none
package srpg_pkg;

	localparam int MOTOR_COUNT_DEF     = 2;
	localparam int RATE_MAX_DEF        = 1000;
	localparam int RATE_MIN_DEF        = 50;
	localparam int MASTER_CLOCK_HZ_DEF = 144000;
	localparam int RAMP_UPDATE_HZ_DEF  = 50;

	localparam int RAMP_DIVIDE  = 48;
	localparam int FAST_TICK_HZ = 14400;
	localparam int STOP_RATE    = 50;
	localparam int ACCEL_LOW    = 100;
	localparam int ACCEL_HIGH   = 10000;
	localparam int ACCEL_RESET  = 3000;
	localparam int RECIP_SHIFT  = 24;

	typedef enum logic [2:0] {
		OP_FAST       = 3'd0,
		OP_RAMP       = 3'd1,
		OP_SET_SPEED  = 3'd2,
		OP_SET_STEPS  = 3'd3,
		OP_ENABLE     = 3'd4,
		OP_DISABLE    = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_REV  = 2'd2
	} dir_t;

	localparam logic REG_RAMP_EN = 1'b0;
	localparam logic REG_ACCEL   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_FAST,
		ST_RAMP,
		ST_SET,
		ST_DIV,
		ST_DIV_WRITE,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_CAPTURE,
		CMD_FAST,
		CMD_RAMP,
		CMD_SET,
		CMD_DIV_STEP,
		CMD_DIV_WRITE,
		CMD_OUT
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
	} ctl_t;

	typedef struct packed {
		op_t  op;
		logic ramp_fire;
		logic needs_div;
		logic div_last;
		logic out_busy;
	} stat_t;

	// Left motor phases give 9,5,6,10; the others give 10,6,5,9.
	function automatic logic [3:0] coils_for(input logic is_left, input logic [1:0] ph);
		logic [3:0] c;
		unique case (ph)
			2'd0: c = is_left ? 4'd9  : 4'd10;
			2'd1: c = is_left ? 4'd5  : 4'd6;
			2'd2: c = is_left ? 4'd6  : 4'd5;
			default: c = is_left ? 4'd10 : 4'd9;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

### src/srpg_ctrl.sv
`default_nettype none
module srpg_ctrl #(
	parameter int MOTOR_COUNT = srpg_pkg::MOTOR_COUNT_DEF,
	parameter int IW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire srpg_pkg::stat_t stat,
	input  wire logic [IW-1:0]   sel,
	output srpg_pkg::ctl_t       ctl,
	output logic [IW-1:0]        idx
);
	import srpg_pkg::*;

	state_t state_q, state_d;
	logic [IW-1:0] idx_q, idx_d;
	logic last_idx;

	assign last_idx = (idx_q == IW'(MOTOR_COUNT - 1));
	assign idx      = idx_q;
	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				priority if (stat.op == OP_FAST) begin
					idx_d = '0; state_d = ST_FAST;
				end else if (stat.op == OP_RAMP && stat.ramp_fire) begin
					idx_d = '0; state_d = ST_RAMP;
				end else if (stat.op == OP_SET_SPEED) begin
					idx_d = sel; state_d = ST_SET;
				end else begin
					idx_d = sel; state_d = ST_OUT;
				end
			end
			ST_FAST: begin
				if (last_idx) begin
					idx_d = sel; state_d = ST_OUT;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_RAMP: begin
				priority if (stat.needs_div) begin
					state_d = ST_DIV;
				end else if (last_idx) begin
					idx_d = sel; state_d = ST_OUT;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_SET: begin
				state_d = stat.needs_div ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				if (stat.div_last) state_d = ST_DIV_WRITE;
			end
			ST_DIV_WRITE: begin
				if (stat.op == OP_RAMP && !last_idx) begin
					idx_d = idx_q + 1'b1; state_d = ST_RAMP;
				end else begin
					idx_d = sel; state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!stat.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.cmd = CMD_NONE;
		unique case (state_q)
			ST_IDLE:      ctl.cmd = s_tvalid ? CMD_CAPTURE : CMD_NONE;
			ST_FAST:      ctl.cmd = CMD_FAST;
			ST_RAMP:      ctl.cmd = CMD_RAMP;
			ST_SET:       ctl.cmd = CMD_SET;
			ST_DIV:       ctl.cmd = CMD_DIV_STEP;
			ST_DIV_WRITE: ctl.cmd = CMD_DIV_WRITE;
			ST_OUT:       ctl.cmd = stat.out_busy ? CMD_NONE : CMD_OUT;
			default:      ctl.cmd = CMD_NONE;
		endcase
	end
endmodule
`default_nettype wire

### src/srpg_datapath.sv
`default_nettype none
module srpg_datapath #(
	parameter int MOTOR_COUNT     = srpg_pkg::MOTOR_COUNT_DEF,
	parameter int RATE_MAX        = srpg_pkg::RATE_MAX_DEF,
	parameter int RATE_MIN        = srpg_pkg::RATE_MIN_DEF,
	parameter int MASTER_CLOCK_HZ = srpg_pkg::MASTER_CLOCK_HZ_DEF,
	parameter int RAMP_UPDATE_HZ  = srpg_pkg::RAMP_UPDATE_HZ_DEF,
	parameter int IW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [31:0]    s_tdata,
	input  wire logic [3:0]     s_tuser,
	input  wire logic           cfg_we,
	input  wire logic           cfg_index,
	input  wire logic [15:0]    cfg_data,
	input  wire srpg_pkg::ctl_t ctl,
	input  wire logic [IW-1:0]  idx,
	output srpg_pkg::stat_t     stat,
	output logic [IW-1:0]       sel,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [31:0]         m_tdata
);
	import srpg_pkg::*;

	localparam int PW  = $clog2(MASTER_CLOCK_HZ + 1);
	localparam int TW  = PW + 2;
	localparam int RW  = $clog2(RATE_MAX + 1);
	localparam int SW  = RW + 1;
	localparam int STW = $clog2(ACCEL_HIGH / RAMP_UPDATE_HZ + 1);
	localparam int EW  = SW + STW + 1;
	localparam int CW  = $clog2(PW);
	localparam int DK  = MASTER_CLOCK_HZ / FAST_TICK_HZ;
	localparam longint RECIP = ((64'd1 << RECIP_SHIFT) + RAMP_UPDATE_HZ - 1) / RAMP_UPDATE_HZ;
	localparam int RCW = $clog2(RECIP + 1);

	logic [1:0]          dir_q     [MOTOR_COUNT];
	logic [1:0]          phase_q   [MOTOR_COUNT];
	logic [PW-1:0]       period_q  [MOTOR_COUNT];
	logic signed [TW-1:0] timer_q  [MOTOR_COUNT];
	logic [15:0]         counter_q [MOTOR_COUNT];
	logic signed [SW-1:0] target_q [MOTOR_COUNT];
	logic signed [SW-1:0] actual_q [MOTOR_COUNT];
	logic [3:0]          coil_q    [MOTOR_COUNT];
	logic [5:0]          prescale_q;
	logic                ramp_en_q;
	logic [15:0]         accel_q;
	logic                fire_q;
	logic [STW-1:0]      step_q;

	op_t                 op_q;
	logic [IW-1:0]       sel_q;
	logic signed [SW-1:0] req_q;

	// Serial restoring divider for the step period.
	logic [RW-1:0]       rate_q;
	logic [RW-1:0]       rem_q;
	logic [PW-1:0]       dvd_q;
	logic [PW-1:0]       quo_q;
	logic [CW-1:0]       cnt_q;
	logic [1:0]          pdir_q;
	logic                ld_timer_q;

	// Input decode and request clamp.
	logic [IW-1:0]        sel_in;
	logic signed [16:0]   spd_in;
	logic signed [SW-1:0] req_c;
	logic [13:0]          accel_c;
	logic [14+RCW-1:0]    prod;

	assign sel_in = (MOTOR_COUNT > 1) ? IW'(s_tuser[3]) : IW'(0);
	assign spd_in = 17'(signed'(s_tdata[15:0]));

	always_comb begin
		if (spd_in > 17'(RATE_MAX))
			req_c = SW'(RATE_MAX);
		else if (spd_in < -17'(RATE_MAX))
			req_c = -SW'(RATE_MAX);
		else if (spd_in < 17'(RATE_MIN) && spd_in > -17'(RATE_MIN))
			req_c = '0;
		else
			req_c = SW'(spd_in);
		if (accel_q < 16'(ACCEL_LOW))
			accel_c = 14'(ACCEL_LOW);
		else if (accel_q > 16'(ACCEL_HIGH))
			accel_c = 14'(ACCEL_HIGH);
		else
			accel_c = accel_q[13:0];
		prod = (14+RCW)'(accel_c) * (14+RCW)'(RECIP);
	end

	// Ramp move for the indexed motor.
	logic signed [EW-1:0] r_w, u_w, s_w, st_w;
	logic signed [SW-1:0] s_c;
	always_comb begin
		r_w  = EW'(target_q[idx]);
		u_w  = EW'(actual_q[idx]);
		st_w = signed'(EW'(step_q));
		if (r_w > u_w) begin
			s_w = u_w + st_w;
			if (s_w > r_w) s_w = r_w;
		end else begin
			s_w = u_w - st_w;
			if (s_w < r_w) s_w = r_w;
		end
		if (s_w > EW'(RATE_MAX)) s_w = EW'(RATE_MAX);
		if (s_w < -EW'(RATE_MAX)) s_w = -EW'(RATE_MAX);
		s_c = SW'(s_w);
	end

	// Rate and direction for the speed being applied.
	logic signed [SW-1:0] mot_spd;
	logic [RW-1:0]        mot_rate;
	dir_t                 mot_dir;
	always_comb begin
		mot_spd = (ctl.cmd == CMD_RAMP) ? s_c : req_q;
		if (mot_spd >= SW'(RATE_MIN)) begin
			mot_rate = RW'(mot_spd);
			mot_dir  = DIR_FWD;
		end else if (mot_spd <= -SW'(RATE_MIN)) begin
			mot_rate = RW'(-mot_spd);
			mot_dir  = DIR_REV;
		end else begin
			mot_rate = RW'(STOP_RATE);
			mot_dir  = DIR_STOP;
		end
	end

	// Fast tick for the indexed motor.
	logic signed [TW-1:0] t1, t2;
	logic                 expire;
	logic [1:0]           ph_up, ph_dn;
	always_comb begin
		t1     = (timer_q[idx] > 0) ? timer_q[idx] - TW'(DK) : timer_q[idx];
		expire = (t1 <= 0);
		t2     = t1 + signed'(TW'(period_q[idx]));
		ph_up  = phase_q[idx] + 2'd1;
		ph_dn  = phase_q[idx] + 2'd3;
	end

	// Divider step.
	logic [RW:0] trial;
	logic        take;
	assign trial = {rem_q, dvd_q[PW-1]};
	assign take  = (trial >= {1'b0, rate_q});

	assign sel            = sel_q;
	assign stat.op        = op_q;
	assign stat.ramp_fire = fire_q;
	assign stat.needs_div = (op_q == OP_RAMP) ? (target_q[idx] != actual_q[idx]) : !ramp_en_q;
	assign stat.div_last  = (cnt_q == CW'(PW - 1));
	assign stat.out_busy  = m_tvalid && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < MOTOR_COUNT; m++) begin
				dir_q[m]     <= DIR_STOP;
				phase_q[m]   <= 2'd0;
				period_q[m]  <= PW'(1);
				timer_q[m]   <= '0;
				counter_q[m] <= '0;
				target_q[m]  <= '0;
				actual_q[m]  <= '0;
				coil_q[m]    <= 4'd0;
			end
			prescale_q <= '0;
			ramp_en_q  <= 1'b1;
			accel_q    <= 16'(ACCEL_RESET);
			fire_q     <= 1'b0;
			op_q       <= OP_FAST;
			sel_q      <= '0;
			m_tvalid   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_RAMP_EN: ramp_en_q <= cfg_data[0];
					REG_ACCEL:   accel_q   <= cfg_data;
					default:     ;
				endcase
			end
			if (m_tvalid && m_tready && ctl.cmd != CMD_OUT) m_tvalid <= 1'b0;
			unique case (ctl.cmd)
				CMD_CAPTURE: begin
					op_q  <= op_t'(s_tuser[2:0]);
					sel_q <= sel_in;
					req_q <= req_c;
					step_q <= STW'(prod >> RECIP_SHIFT);
					fire_q <= 1'b0;
					unique case (s_tuser[2:0])
						OP_RAMP: begin
							if (prescale_q == 6'(RAMP_DIVIDE - 1)) begin
								prescale_q <= '0;
								fire_q     <= 1'b1;
							end else begin
								prescale_q <= prescale_q + 6'd1;
							end
						end
						OP_SET_STEPS: counter_q[sel_in] <= s_tdata[31:16];
						OP_ENABLE:    prescale_q <= '0;
						OP_DISABLE: begin
							for (int m = 0; m < MOTOR_COUNT; m++) begin
								timer_q[m] <= '0;
								coil_q[m]  <= 4'd0;
							end
						end
						default: ;
					endcase
				end
				CMD_FAST: begin
					if (expire) begin
						timer_q[idx] <= t2;
						if (dir_q[idx] == DIR_FWD) begin
							counter_q[idx] <= counter_q[idx] + 16'd1;
							phase_q[idx]   <= ph_up;
							coil_q[idx]    <= coils_for(idx == '0, ph_up);
						end else if (dir_q[idx] == DIR_REV) begin
							counter_q[idx] <= counter_q[idx] - 16'd1;
							phase_q[idx]   <= ph_dn;
							coil_q[idx]    <= coils_for(idx == '0, ph_dn);
						end else begin
							coil_q[idx] <= 4'd0;
						end
					end else begin
						timer_q[idx] <= t1;
					end
				end
				CMD_RAMP, CMD_SET: begin
					if (ctl.cmd == CMD_SET && ramp_en_q) begin
						target_q[idx] <= req_q;
					end else if (stat.needs_div) begin
						actual_q[idx] <= mot_spd;
						if (ctl.cmd == CMD_SET) target_q[idx] <= req_q;
						rate_q     <= mot_rate;
						pdir_q     <= mot_dir;
						ld_timer_q <= (ctl.cmd == CMD_SET);
						rem_q      <= '0;
						dvd_q      <= PW'(MASTER_CLOCK_HZ);
						quo_q      <= '0;
						cnt_q      <= '0;
					end
				end
				CMD_DIV_STEP: begin
					rem_q <= take ? RW'(trial - {1'b0, rate_q}) : trial[RW-1:0];
					quo_q <= {quo_q[PW-2:0], take};
					dvd_q <= {dvd_q[PW-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
				end
				CMD_DIV_WRITE: begin
					period_q[idx] <= quo_q;
					dir_q[idx]    <= pdir_q;
					if (ld_timer_q) timer_q[idx] <= signed'(TW'(quo_q));
				end
				CMD_OUT: begin
					m_tvalid <= 1'b1;
					m_tdata  <= {6'd0, dir_q[idx], counter_q[idx],
						(MOTOR_COUNT > 1) ? coil_q[(MOTOR_COUNT > 1) ? 1 : 0] : 4'd0,
						coil_q[0]};
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

### src/stepper_ramp_phase_generator.sv
// Channel   Direction  Contents
// s_*       in         tdata: speed_request[15:0], step_value[31:16]; tuser: op, motor_sel
// m_*       out        tdata: left_coils, right_coils, step_count, sel_direction
// cfg_*     in         write-only registers: 0 ramp_enabled, 1 accel_rate
//
// One item at a time. Set steps, enable, disable and a ramp tick that does not
// fire go straight to the output; a fast tick first steps every motor in turn. A
// speed change with ramping off runs the serial period divider for its motor, and
// a firing ramp tick runs it for each motor whose speed still has to move.
// Reset is asynchronous, active low, and restores every motor at once.
// A result still waiting in the output register holds the next item in its last cycle.
`default_nettype none
module stepper_ramp_phase_generator #(
	parameter int MOTOR_COUNT     = srpg_pkg::MOTOR_COUNT_DEF,
	parameter int RATE_MAX        = srpg_pkg::RATE_MAX_DEF,
	parameter int RATE_MIN        = srpg_pkg::RATE_MIN_DEF,
	parameter int MASTER_CLOCK_HZ = srpg_pkg::MASTER_CLOCK_HZ_DEF,
	parameter int RAMP_UPDATE_HZ  = srpg_pkg::RAMP_UPDATE_HZ_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // speed_request[15:0], step_value[31:16]
	input  wire logic [3:0]  s_tuser,   // op[2:0], motor_sel[3]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // left_coils[3:0], right_coils[7:4],
	                                    // step_count[23:8], sel_direction[25:24]
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);
	import srpg_pkg::*;

	localparam int IW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	ctl_t          ctl;
	stat_t         stat;
	logic [IW-1:0] idx;
	logic [IW-1:0] sel;

	srpg_ctrl #(.MOTOR_COUNT(MOTOR_COUNT), .IW(IW)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.stat(stat), .sel(sel), .ctl(ctl), .idx(idx)
	);

	srpg_datapath #(
		.MOTOR_COUNT(MOTOR_COUNT), .RATE_MAX(RATE_MAX), .RATE_MIN(RATE_MIN),
		.MASTER_CLOCK_HZ(MASTER_CLOCK_HZ), .RAMP_UPDATE_HZ(RAMP_UPDATE_HZ), .IW(IW)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.ctl(ctl), .idx(idx), .stat(stat), .sel(sel),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);
endmodule
`default_nettype wire

### src/srpg_checker.sv
`default_nettype none
`include "stepper_ramp_phase_generator_assert.svh"
module srpg_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);
	// An accepted item keeps the input closed while it is worked on.
	`SRPG_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
	// A new result only appears as the block returns to idle.
	`SRPG_ASSERT_NOW(a_result_from_work, $rose(m_tvalid), s_tready && !$past(s_tready),
		"result without work")
	// The direction code is never the unused value.
	`SRPG_ASSERT_NOW(a_dir_code, m_tvalid, m_tdata[25:24] != 2'b11, "bad direction code")
	// A stalled result holds.
	`SRPG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
		"stalled result changed")
endmodule

bind stepper_ramp_phase_generator srpg_checker u_srpg_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
